[hw/rtl/csrh_pkg.sv]
// ----------------------------------------------------------------------------
// csrh_pkg
// Shared types and constants for the CSR row product block with halo windows.
// ----------------------------------------------------------------------------
`default_nettype none

package csrh_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD_LOCAL = 2'd0,
        CMD_LOAD_LOWER = 2'd1,
        CMD_LOAD_UPPER = 2'd2,
        CMD_NONZERO    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_FIRST_ROW  = 2'd0,
        CFG_LOCAL_ROWS = 2'd1,
        CFG_HALO_WIDTH = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SEL_NONE  = 2'd0,
        SEL_LOCAL = 2'd1,
        SEL_LOWER = 2'd2,
        SEL_UPPER = 2'd3
    } win_sel_t;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [23:0] FIRST_ROW_RST  = 24'd0;
    localparam logic [12:0] LOCAL_ROWS_RST = 13'd4096;
    localparam logic [10:0] HALO_WIDTH_RST = 11'd1024;

    // result queue
    localparam int OUTQ_DEPTH = 8;
    localparam int OUTQ_AW    = 3;
    localparam int OUTQ_CW    = 4;

    localparam logic signed [31:0] SUM_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SUM_MIN = 32'sh8000_0000;
    localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] ACC_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic [1:0]         command;
        logic [11:0]        slot;
        logic signed [31:0] value;
        logic [23:0]        column;
        logic [11:0]        row;
        logic               row_last;
        logic               has_entry;
    } in_item_t;

    typedef struct packed {
        logic [11:0]        row_index;
        logic signed [31:0] row_sum;
        logic               overflow;
        logic               column_error;
    } out_item_t;

    typedef struct packed {
        logic [23:0] first_row;
        logic [12:0] local_rows;
        logic [10:0] halo_width;
    } cfg_t;

    // control of one nonzero on its way to the accumulator
    typedef struct packed {
        logic        valid;
        logic        has_entry;
        logic        row_last;
        logic        hit;
        logic [11:0] row;
    } nz_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/csrh_ram.sv]
// ----------------------------------------------------------------------------
// csrh_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module csrh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hw/rtl/csrh_window.sv]
// ----------------------------------------------------------------------------
// csrh_window
// Maps a global column onto the local slice or one of the two halo planes.
// ----------------------------------------------------------------------------
`default_nettype none

module csrh_window #(
    parameter int LOCAL_DEPTH = 4096,
    parameter int PLANE_DEPTH = 1024,
    localparam int LAW        = $clog2(LOCAL_DEPTH),
    localparam int PAW        = $clog2(PLANE_DEPTH)
) (
    input  wire csrh_pkg::cfg_t   cfg,
    input  wire logic [23:0]      column,
    output csrh_pkg::win_sel_t    sel,
    output logic [LAW-1:0]        local_addr,
    output logic [PAW-1:0]        plane_addr
);

    localparam logic signed [25:0] LOC_LIM = 26'(LOCAL_DEPTH);
    localparam logic signed [25:0] PLN_LIM = 26'(PLANE_DEPTH);

    logic signed [25:0] diff;
    logic signed [25:0] k_low;
    logic signed [25:0] k_up;
    logic signed [25:0] rows_ext;
    logic signed [25:0] plane_ext;
    logic               below;
    logic               in_local;
    logic               local_ok;
    logic               lower_ok;
    logic               upper_ok;

    assign rows_ext  = $signed({13'b0, cfg.local_rows});
    assign plane_ext = $signed({15'b0, cfg.halo_width});

    assign diff     = $signed({2'b00, column}) - $signed({2'b00, cfg.first_row});
    assign below    = diff[25];
    assign in_local = !below && (diff < rows_ext);

    // lower halo slot = halo_width - (first_row - column)
    assign k_low = diff + plane_ext;
    // upper halo slot = column - (first_row + local_rows)
    assign k_up  = diff - rows_ext;

    // inside the local window but past the store: no fall-through to a halo
    assign local_ok = in_local && (diff < LOC_LIM);
    assign lower_ok = below && !k_low[25] && (k_low < PLN_LIM);
    assign upper_ok = !below && !in_local && (k_up < plane_ext) && (k_up < PLN_LIM);

    always_comb begin
        if (local_ok) begin
            sel = csrh_pkg::SEL_LOCAL;
        end else if (lower_ok) begin
            sel = csrh_pkg::SEL_LOWER;
        end else if (upper_ok) begin
            sel = csrh_pkg::SEL_UPPER;
        end else begin
            sel = csrh_pkg::SEL_NONE;
        end
    end

    assign local_addr = diff[LAW-1:0];
    assign plane_addr = below ? k_low[PAW-1:0] : k_up[PAW-1:0];

endmodule

`default_nettype wire

[hw/rtl/csrh_mac.sv]
// ----------------------------------------------------------------------------
// csrh_mac
// Product register, saturating Q32.32 accumulator and Q16.16 row result.
// ----------------------------------------------------------------------------
`default_nettype none

module csrh_mac (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire csrh_pkg::nz_ctl_t   nz,
    input  wire logic signed [31:0]  value,
    input  wire logic signed [31:0]  elem,
    output logic                     push,
    output csrh_pkg::out_item_t      push_item,
    output logic [1:0]               pending
);

    csrh_pkg::nz_ctl_t  ctl_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] prod_next;

    logic signed [63:0] acc_reg;
    logic signed [63:0] acc_next;
    logic               err_reg;
    logic               err_next;

    logic               emit_reg;
    logic signed [63:0] emit_acc_reg;
    logic               emit_err_reg;
    logic [11:0]        emit_row_reg;

    logic signed [63:0] sum;
    logic signed [63:0] acc_sat;
    logic signed [63:0] acc_upd;
    logic               err_upd;
    logic               add_en;
    logic               close;
    logic [16:0]        top_bits;
    logic               sat;

    assign prod_next = value * elem;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= nz;
        end
        prod_reg <= prod_next;
    end

    // saturating 64-bit add
    assign sum = acc_reg + prod_reg;
    always_comb begin
        if (!acc_reg[63] && !prod_reg[63] && sum[63]) begin
            acc_sat = csrh_pkg::ACC_MAX;
        end else if (acc_reg[63] && prod_reg[63] && !sum[63]) begin
            acc_sat = csrh_pkg::ACC_MIN;
        end else begin
            acc_sat = sum;
        end
    end

    assign add_en  = ctl_reg.valid && ctl_reg.has_entry && ctl_reg.hit;
    assign acc_upd = add_en ? acc_sat : acc_reg;
    assign err_upd = err_reg | (ctl_reg.valid && ctl_reg.has_entry && !ctl_reg.hit);
    assign close   = ctl_reg.valid && ctl_reg.row_last;

    assign acc_next = close ? '0 : acc_upd;
    assign err_next = close ? 1'b0 : err_upd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            err_reg  <= 1'b0;
            emit_reg <= 1'b0;
        end else begin
            acc_reg  <= acc_next;
            err_reg  <= err_next;
            emit_reg <= close;
        end
        if (close) begin
            emit_acc_reg <= acc_upd;
            emit_err_reg <= err_upd;
            emit_row_reg <= ctl_reg.row;
        end
    end

    // floor shift by 16 is the arithmetic shift; saturate unless bits 63..47 agree
    assign top_bits = emit_acc_reg[63:47];
    assign sat      = !((&top_bits) || !(|top_bits));

    always_comb begin
        push_item.row_index    = emit_row_reg;
        push_item.overflow     = sat;
        push_item.column_error = emit_err_reg;
        if (sat) begin
            push_item.row_sum = emit_acc_reg[63] ? csrh_pkg::SUM_MIN : csrh_pkg::SUM_MAX;
        end else begin
            push_item.row_sum = emit_acc_reg[47:16];
        end
    end

    assign push    = emit_reg;
    assign pending = {1'b0, close} + {1'b0, emit_reg};

endmodule

`default_nettype wire

[hw/rtl/csrh_outq.sv]
// ----------------------------------------------------------------------------
// csrh_outq
// Small result queue between the accumulator and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module csrh_outq (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          push,
    input  wire csrh_pkg::out_item_t           push_item,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output csrh_pkg::out_item_t                m_data,
    output logic [csrh_pkg::OUTQ_CW-1:0]       count
);

    csrh_pkg::out_item_t              buf_reg [csrh_pkg::OUTQ_DEPTH];
    logic [csrh_pkg::OUTQ_AW-1:0]     wptr_reg;
    logic [csrh_pkg::OUTQ_AW-1:0]     rptr_reg;
    logic [csrh_pkg::OUTQ_CW-1:0]     count_reg;
    logic [csrh_pkg::OUTQ_CW-1:0]     count_next;
    logic                             pop;

    assign pop = m_valid && m_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
        if (push) begin
            buf_reg[wptr_reg] <= push_item;
        end
    end

    assign m_valid = (count_reg != '0);
    assign m_data  = buf_reg[rptr_reg];
    assign count   = count_reg;

endmodule

`default_nettype wire

[hw/rtl/csr_spmv_row_with_halo.sv]
// ----------------------------------------------------------------------------
// csr_spmv_row_with_halo
// CSR sparse row product against a local vector slice with two halo planes.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while s_ready is high, loads and nonzeros alike.
// Path: a row-closing nonzero reaches m_valid through the input reg, window/RAM
// read, multiply, accumulate and result queue registers.
// s_ready drops only when the 8-entry result queue plus rows in flight is full.
// Reset: clears pipeline control, accumulator, error flag and result queue;
// registers return to 0 / 4096 / 1024. Vector stores are not cleared.
`default_nettype none

module csr_spmv_row_with_halo #(
    parameter int LOCAL_DEPTH = 4096,
    parameter int PLANE_DEPTH = 1024
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire csrh_pkg::in_item_t                 s_data,

    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output csrh_pkg::out_item_t                     m_data,

    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [csrh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [csrh_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int LAW = $clog2(LOCAL_DEPTH);
    localparam int PAW = $clog2(PLANE_DEPTH);
    localparam logic [25:0] LOC_LIM = 26'(LOCAL_DEPTH);
    localparam logic [25:0] PLN_LIM = 26'(PLANE_DEPTH);

    csrh_pkg::cfg_t      cfg_reg;

    logic                in_valid_reg;
    csrh_pkg::in_item_t  item_reg;

    csrh_pkg::win_sel_t  win_sel;
    logic [LAW-1:0]      win_local_addr;
    logic [PAW-1:0]      win_plane_addr;

    logic [25:0]         slot_ext;
    logic                is_nz;
    logic                we_local;
    logic                we_lower;
    logic                we_upper;
    logic [LAW-1:0]      local_waddr;
    logic [PAW-1:0]      plane_waddr;

    logic [31:0]         local_rdata;
    logic [31:0]         lower_rdata;
    logic [31:0]         upper_rdata;

    csrh_pkg::nz_ctl_t   nz_reg;
    csrh_pkg::nz_ctl_t   nz_next;
    csrh_pkg::win_sel_t  sel_reg;
    logic signed [31:0]  value_reg;
    logic signed [31:0]  elem;

    logic                q_push;
    csrh_pkg::out_item_t q_item;
    logic [1:0]          mac_pending;
    logic [csrh_pkg::OUTQ_CW-1:0] q_count;

    logic                r1_emit;
    logic                r2_emit;
    logic [2:0]          pending;
    logic [4:0]          credit_used;

    // ---- configuration ----
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first_row  <= csrh_pkg::FIRST_ROW_RST;
            cfg_reg.local_rows <= csrh_pkg::LOCAL_ROWS_RST;
            cfg_reg.halo_width <= csrh_pkg::HALO_WIDTH_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                csrh_pkg::CFG_FIRST_ROW:  cfg_reg.first_row  <= cfg_data;
                csrh_pkg::CFG_LOCAL_ROWS: cfg_reg.local_rows <= cfg_data[12:0];
                csrh_pkg::CFG_HALO_WIDTH: cfg_reg.halo_width <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // ---- input register ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= s_valid && s_ready;
        end
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
    end

    // ---- window decode and store access ----
    csrh_window #(
        .LOCAL_DEPTH (LOCAL_DEPTH),
        .PLANE_DEPTH (PLANE_DEPTH)
    ) u_window (
        .cfg        (cfg_reg),
        .column     (item_reg.column),
        .sel        (win_sel),
        .local_addr (win_local_addr),
        .plane_addr (win_plane_addr)
    );

    assign slot_ext    = 26'(item_reg.slot);
    assign local_waddr = slot_ext[LAW-1:0];
    assign plane_waddr = slot_ext[PAW-1:0];
    assign is_nz       = (item_reg.command == csrh_pkg::CMD_NONZERO);

    // out-of-range load slots are dropped
    assign we_local = in_valid_reg && (item_reg.command == csrh_pkg::CMD_LOAD_LOCAL)
                      && (slot_ext < LOC_LIM);
    assign we_lower = in_valid_reg && (item_reg.command == csrh_pkg::CMD_LOAD_LOWER)
                      && (slot_ext < PLN_LIM);
    assign we_upper = in_valid_reg && (item_reg.command == csrh_pkg::CMD_LOAD_UPPER)
                      && (slot_ext < PLN_LIM);

    csrh_ram #(.WIDTH(32), .DEPTH(LOCAL_DEPTH)) u_local_ram (
        .aclk  (aclk),
        .we    (we_local),
        .waddr (local_waddr),
        .wdata (item_reg.value),
        .raddr (win_local_addr),
        .rdata (local_rdata)
    );

    csrh_ram #(.WIDTH(32), .DEPTH(PLANE_DEPTH)) u_lower_ram (
        .aclk  (aclk),
        .we    (we_lower),
        .waddr (plane_waddr),
        .wdata (item_reg.value),
        .raddr (win_plane_addr),
        .rdata (lower_rdata)
    );

    csrh_ram #(.WIDTH(32), .DEPTH(PLANE_DEPTH)) u_upper_ram (
        .aclk  (aclk),
        .we    (we_upper),
        .waddr (plane_waddr),
        .wdata (item_reg.value),
        .raddr (win_plane_addr),
        .rdata (upper_rdata)
    );

    // ---- read stage, lines up with registered RAM data ----
    always_comb begin
        nz_next.valid     = in_valid_reg && is_nz;
        nz_next.has_entry = item_reg.has_entry;
        nz_next.row_last  = item_reg.row_last;
        nz_next.hit       = (win_sel != csrh_pkg::SEL_NONE);
        nz_next.row       = item_reg.row;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nz_reg <= '0;
        end else begin
            nz_reg <= nz_next;
        end
        sel_reg   <= win_sel;
        value_reg <= item_reg.value;
    end

    always_comb begin
        case (sel_reg)
            csrh_pkg::SEL_LOCAL: elem = local_rdata;
            csrh_pkg::SEL_LOWER: elem = lower_rdata;
            csrh_pkg::SEL_UPPER: elem = upper_rdata;
            default:             elem = '0;
        endcase
    end

    csrh_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .nz        (nz_reg),
        .value     (value_reg),
        .elem      (elem),
        .push      (q_push),
        .push_item (q_item),
        .pending   (mac_pending)
    );

    csrh_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .count     (q_count)
    );

    // ---- credit: every row close in flight has a queue slot reserved ----
    assign r1_emit     = in_valid_reg && is_nz && item_reg.row_last;
    assign r2_emit     = nz_reg.valid && nz_reg.row_last;
    assign pending     = {2'b0, r1_emit} + {2'b0, r2_emit} + {1'b0, mac_pending};
    assign credit_used = 5'(q_count) + 5'(pending);
    assign s_ready     = (credit_used < 5'(csrh_pkg::OUTQ_DEPTH));

    // ---- assertions ----
    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        credit_used <= 5'(csrh_pkg::OUTQ_DEPTH))
        else $error("result queue over-committed");

    a_close_reaches_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        r1_emit |-> ##3 q_push)
        else $error("row close did not reach the result queue");

    a_push_has_source: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> $past(r1_emit, 3))
        else $error("result pushed without a row close");

endmodule

`default_nettype wire
